@@ rtl/mssc_pkg.sv @@
package mssc_pkg;

  // Byte codes the filter reacts to.
  localparam logic [7:0] LEAD_BYTE    = 8'hC2;
  localparam logic [7:0] PILCROW_TAIL = 8'hB6;
  localparam logic [7:0] TAG_OPEN     = 8'h3C;
  localparam logic [7:0] TAG_CLOSE    = 8'h3E;
  localparam logic [7:0] SPACE_BYTE   = 8'h20;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] RETURN_BYTE  = 8'h0D;
  localparam logic [7:0] TAB_BYTE     = 8'h09;
  localparam logic [7:0] NUL_BYTE     = 8'h00;

  // Buffer size after reset.
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd512;

  // One input item can cause a held space, a held lead byte and one more byte.
  localparam int unsigned GROUP_DEPTH = 3;
  localparam int unsigned GROUP_IDX_W = $clog2(GROUP_DEPTH);
  localparam int unsigned GROUP_CNT_W = $clog2(GROUP_DEPTH + 1);

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       text_done;
  } clean_item_t;

endpackage

@@ rtl/markup_strip_space_collapse_unit.sv @@
// Markup stripping and space collapsing text filter.
//
// Text bytes arrive on the text channel (text_valid, text_ready, text_item),
// one byte per transfer. Cleaned bytes and a final terminator leave on the
// clean channel (clean_valid, clean_ready, clean_item). The cfg channel
// writes max_length, the buffer size; at most max_length-1 bytes come out.
// Write it only while the block is idle.
//
// An accepted item waits in the input register; its results are then loaded
// into the result group register, which offers them on the clean channel.
// The block takes one item per cycle while the receiver keeps up and each
// item gives at most one result. An item with more results (up to three:
// a held space, a held 0xC2 and the current byte or the terminator) holds
// the result group until all are taken; the input register waits behind it.
// Items that give no result never wait for the output side.
// When the receiver stalls, the result group holds, then the input register
// fills and text_ready drops. Synchronous reset empties both registers,
// clears the filter state and sets max_length back to 512.
module markup_strip_space_collapse_unit
  import mssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  text_item_t  text_item,
  output logic        clean_valid,
  input  logic        clean_ready,
  output clean_item_t clean_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_length
);

  // Configuration register.
  logic [15:0] max_length;

  // Filter state.
  logic        inside_tag;
  logic        space_pending;
  logic        lead_byte_pending;
  logic [15:0] written_count;

  // Input register.
  logic       a_valid;
  text_item_t a_item;

  // Result group register.
  logic                   b_valid;
  clean_item_t            grp [GROUP_DEPTH];
  logic [GROUP_CNT_W-1:0] grp_cnt;
  logic [GROUP_IDX_W-1:0] grp_idx;

  // Results and next state for the item in the input register.
  clean_item_t            res [GROUP_DEPTH];
  logic [GROUP_CNT_W-1:0] res_n;
  logic                   inside_tag_next;
  logic                   space_pending_next;
  logic                   lead_byte_pending_next;
  logic [15:0]            written_count_next;
  logic                   a_end;

  logic b_take;
  logic b_take_last;
  logic b_free;
  logic a_advance;

  assign cfg_ready = 1'b1;

  // Work out every result of one byte in a single pass.
  always_comb begin
    logic [15:0] limit;
    logic [7:0]  c;
    logic        stop;
    limit = (max_length == 16'd0) ? 16'd0 : max_length - 16'd1;
    c     = a_item.text_byte;
    stop  = 1'b0;
    a_end = a_item.end_of_text || (c == NUL_BYTE);

    for (int i = 0; i < GROUP_DEPTH; i++) begin
      res[i] = '{out_byte: NUL_BYTE, text_done: 1'b0};
    end
    res_n                  = '0;
    inside_tag_next        = inside_tag;
    space_pending_next     = space_pending;
    lead_byte_pending_next = lead_byte_pending;
    written_count_next     = written_count;

    if (a_end) begin
      // Flush a held lead byte (after a held space, if any), then close the text and clear the state.
      if (lead_byte_pending) begin
        if (space_pending) begin
          res[res_n[GROUP_IDX_W-1:0]] = '{out_byte: SPACE_BYTE, text_done: 1'b0};
          res_n = res_n + GROUP_CNT_W'(1);
        end
        res[res_n[GROUP_IDX_W-1:0]] = '{out_byte: LEAD_BYTE, text_done: 1'b0};
        res_n = res_n + GROUP_CNT_W'(1);
      end
      res[res_n[GROUP_IDX_W-1:0]] = '{out_byte: NUL_BYTE, text_done: 1'b1};
      res_n = res_n + GROUP_CNT_W'(1);
      inside_tag_next        = 1'b0;
      space_pending_next     = 1'b0;
      lead_byte_pending_next = 1'b0;
      written_count_next     = '0;
    end else begin
      // A held lead byte is either half of a pilcrow or goes out now.
      if (lead_byte_pending) begin
        lead_byte_pending_next = 1'b0;
        if (c == PILCROW_TAIL) begin
          stop = 1'b1;
        end else begin
          if (space_pending) begin
            res[res_n[GROUP_IDX_W-1:0]] = '{out_byte: SPACE_BYTE, text_done: 1'b0};
            res_n = res_n + GROUP_CNT_W'(1);
            space_pending_next = 1'b0;
          end
          res[res_n[GROUP_IDX_W-1:0]] = '{out_byte: LEAD_BYTE, text_done: 1'b0};
          res_n = res_n + GROUP_CNT_W'(1);
          written_count_next = written_count + 16'd1;
        end
      end

      // The current byte, unless the limit has been reached.
      if (!stop && (written_count_next < limit)) begin
        if (c == TAG_OPEN) begin
          inside_tag_next = 1'b1;
        end else if (c == TAG_CLOSE) begin
          inside_tag_next = 1'b0;
        end else if (!inside_tag) begin
          if (c == LEAD_BYTE) begin
            lead_byte_pending_next = 1'b1;
          end else begin
            if (c == NEWLINE_BYTE || c == RETURN_BYTE || c == TAB_BYTE) begin
              c = SPACE_BYTE;
            end
            if (c == SPACE_BYTE) begin
              if (!space_pending_next) begin
                space_pending_next = 1'b1;
                written_count_next = written_count_next + 16'd1;
              end
            end else begin
              if (space_pending_next) begin
                res[res_n[GROUP_IDX_W-1:0]] = '{out_byte: SPACE_BYTE, text_done: 1'b0};
                res_n = res_n + GROUP_CNT_W'(1);
                space_pending_next = 1'b0;
              end
              res[res_n[GROUP_IDX_W-1:0]] = '{out_byte: c, text_done: 1'b0};
              res_n = res_n + GROUP_CNT_W'(1);
              written_count_next = written_count_next + 16'd1;
            end
          end
        end
      end
    end
  end

  // Handshake between the two registers and the ports.
  assign clean_valid = b_valid;
  assign clean_item  = grp[grp_idx];
  assign b_take      = b_valid && clean_ready;
  assign b_take_last = b_take && (GROUP_CNT_W'(grp_idx) == (grp_cnt - GROUP_CNT_W'(1)));
  assign b_free      = !b_valid || b_take_last;
  assign a_advance   = a_valid && ((res_n == '0) || b_free);
  assign text_ready  = !a_valid || a_advance;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length <= cfg_max_length;
    end
  end

  // Filter state commits when the item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_tag        <= 1'b0;
      space_pending     <= 1'b0;
      lead_byte_pending <= 1'b0;
      written_count     <= '0;
    end else if (a_advance) begin
      inside_tag        <= inside_tag_next;
      space_pending     <= space_pending_next;
      lead_byte_pending <= lead_byte_pending_next;
      written_count     <= written_count_next;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (text_valid && text_ready) begin
      a_valid <= 1'b1;
    end else if (a_advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && text_ready) begin
      a_item <= text_item;
    end
  end

  // Result group register, shifted out one entry per transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      grp_cnt <= '0;
      grp_idx <= '0;
    end else if (a_advance && (res_n != '0)) begin
      b_valid <= 1'b1;
      grp_cnt <= res_n;
      grp_idx <= '0;
    end else if (b_take_last) begin
      b_valid <= 1'b0;
    end else if (b_take) begin
      grp_idx <= grp_idx + GROUP_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance && (res_n != '0)) begin
      for (int i = 0; i < GROUP_DEPTH; i++) begin
        grp[i] <= res[i];
      end
    end
  end

  // A result group on the port always has an entry left to send.
  assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (grp_cnt != '0) && (GROUP_CNT_W'(grp_idx) < grp_cnt))
    else $error("result group index outside its fill");

  // A lead byte is only held outside a tag.
  assert property (@(posedge clk) disable iff (rst)
    lead_byte_pending |-> !inside_tag)
    else $error("lead byte held inside a tag");

  // The end of a text leaves the filter state cleared.
  assert property (@(posedge clk) disable iff (rst)
    (a_advance && a_end) |=> !inside_tag && !space_pending && !lead_byte_pending
                             && (written_count == '0))
    else $error("filter state not cleared after end of text");

  // An item accepted from the text channel lands in the input register.
  assert property (@(posedge clk) disable iff (rst)
    (text_valid && text_ready) |=> a_valid)
    else $error("accepted item lost");

endmodule

@@ tb/clean_text_checker.sv @@
`timescale 1ns / 1ps

// Watches the text, clean and cfg channels of the filter. It keeps its own
// copy of the filter state, works out the cleaned bytes that each text
// transfer must cause, and compares every clean transfer with the oldest
// byte still owed.
module clean_text_checker
  import mssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  input  logic        text_ready,
  input  text_item_t  text_item,
  input  logic        clean_valid,
  input  logic        clean_ready,
  input  clean_item_t clean_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_max_length,
  output int          mismatches,
  output int          results_owed
);

  // Filter state as the block should hold it.
  logic [15:0] buffer_size;
  logic        in_tag;
  logic        space_held;
  logic        lead_held;
  logic [15:0] counted;

  clean_item_t clean_bytes_owed[$];
  clean_item_t oldest;
  int          error_total = 0;

  task automatic owe_clean(input logic [7:0] b, input logic done);
    clean_item_t e;
    e.out_byte  = b;
    e.text_done = done;
    clean_bytes_owed.push_back(e);
  endtask

  // A visible byte goes out after the held space, if one is held.
  task automatic emit_visible(input logic [7:0] b);
    if (space_held) begin
      owe_clean(SPACE_BYTE, 1'b0);
      space_held = 1'b0;
    end
    owe_clean(b, 1'b0);
    counted = counted + 16'd1;
  endtask

  task automatic clear_text();
    in_tag     = 1'b0;
    space_held = 1'b0;
    lead_held  = 1'b0;
    counted    = '0;
  endtask

  // Works out the cleaned bytes caused by one accepted text byte.
  task automatic filter_text_byte(input text_item_t it);
    logic [7:0]  c;
    logic [15:0] budget;
    c      = it.text_byte;
    budget = (buffer_size == '0) ? '0 : buffer_size - 16'd1;

    // End of text flushes a held lead byte and closes with the terminator.
    if (it.end_of_text || c == NUL_BYTE) begin
      if (lead_held)
        emit_visible(LEAD_BYTE);
      owe_clean(NUL_BYTE, 1'b1);
      clear_text();
      return;
    end

    // A held lead byte is dropped with a pilcrow tail, else it goes out first.
    if (lead_held) begin
      lead_held = 1'b0;
      if (c == PILCROW_TAIL)
        return;
      emit_visible(LEAD_BYTE);
    end

    if (counted >= budget)
      return;

    if (c == TAG_OPEN) begin
      in_tag = 1'b1;
    end else if (c == TAG_CLOSE) begin
      in_tag = 1'b0;
    end else if (!in_tag) begin
      if (c == LEAD_BYTE) begin
        lead_held = 1'b1;
      end else begin
        if (c == NEWLINE_BYTE || c == RETURN_BYTE || c == TAB_BYTE)
          c = SPACE_BYTE;
        if (c == SPACE_BYTE) begin
          if (!space_held) begin
            space_held = 1'b1;
            counted    = counted + 16'd1;
          end
        end else begin
          emit_visible(c);
        end
      end
    end
  endtask

  // Every transfer is taken from the values that stood before the edge.
  always @(posedge clk) begin
    if (rst) begin
      buffer_size = MAX_LENGTH_RESET;
      clear_text();
      clean_bytes_owed.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        buffer_size = cfg_max_length;
      if (text_valid && text_ready)
        filter_text_byte(text_item);
      if (clean_valid && clean_ready) begin
        if (clean_bytes_owed.size() == 0) begin
          error_total++;
          $display("%0t: unexpected clean transfer: expected none, got byte %h done %b",
                   $time, clean_item.out_byte, clean_item.text_done);
        end else begin
          oldest = clean_bytes_owed.pop_front();
          if (clean_item.out_byte !== oldest.out_byte ||
              clean_item.text_done !== oldest.text_done) begin
            error_total++;
            $display("%0t: clean mismatch: expected byte %h done %b, got byte %h done %b",
                     $time, oldest.out_byte, oldest.text_done,
                     clean_item.out_byte, clean_item.text_done);
          end
        end
      end
    end
    results_owed <= clean_bytes_owed.size();
    mismatches   <= error_total;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import mssc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst;
  logic        text_valid;
  logic        text_ready;
  text_item_t  text_item;
  logic        clean_valid;
  logic        clean_ready;
  clean_item_t clean_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_max_length;

  int mismatches;
  int results_owed;
  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;

  text_item_t text_seq[$];

  always #5 clk = ~clk;

  markup_strip_space_collapse_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .text_valid     (text_valid),
    .text_ready     (text_ready),
    .text_item      (text_item),
    .clean_valid    (clean_valid),
    .clean_ready    (clean_ready),
    .clean_item     (clean_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_max_length (cfg_max_length)
  );

  clean_text_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .text_valid     (text_valid),
    .text_ready     (text_ready),
    .text_item      (text_item),
    .clean_valid    (clean_valid),
    .clean_ready    (clean_ready),
    .clean_item     (clean_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_max_length (cfg_max_length),
    .mismatches     (mismatches),
    .results_owed   (results_owed)
  );

  // The receiver stalls at random at the current rate.
  always @(posedge clk) begin
    clean_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b, input logic e);
    text_item_t it;
    it.text_byte   = b;
    it.end_of_text = e;
    text_seq.push_back(it);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0:       return SPACE_BYTE;
      1:       return TAB_BYTE;
      2:       return NEWLINE_BYTE;
      default: return RETURN_BYTE;
    endcase
  endfunction

  // Appends one text: mostly words, blanks, tags and pilcrow pairs, sometimes
  // plain noise, always closed by an end flag or a zero byte.
  task automatic build_text();
    int pieces;
    int len;
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(1, 16);
      repeat (len) put(8'($urandom_range(255)), $urandom_range(15) == 0);
    end else begin
      pieces = $urandom_range(1, 8);
      repeat (pieces) begin
        case ($urandom_range(7))
          0: repeat ($urandom_range(1, 5)) put(8'($urandom_range(33, 126)), 1'b0);
          1: repeat ($urandom_range(1, 3)) put(pick_blank(), 1'b0);
          2: begin
            put(TAG_OPEN, 1'b0);
            repeat ($urandom_range(0, 4)) put(8'($urandom_range(1, 255)), 1'b0);
            put(TAG_CLOSE, 1'b0);
          end
          3: begin
            put(LEAD_BYTE, 1'b0);
            put(PILCROW_TAIL, 1'b0);
          end
          4: begin
            put(LEAD_BYTE, 1'b0);
            put(8'($urandom_range(1, 255)), 1'b0);
          end
          5: put(8'($urandom_range(1, 255)), 1'b0);
          6: put(TAG_CLOSE, 1'b0);
          default: begin
            put(LEAD_BYTE, 1'b0);
            put($urandom_range(1) ? pick_blank() : TAG_OPEN, 1'b0);
          end
        endcase
      end
      // Sometimes a lead byte is still held when the text ends.
      if ($urandom_range(2) == 0)
        put(LEAD_BYTE, 1'b0);
    end
    if ($urandom_range(1))
      put(8'($urandom_range(255)), 1'b1);
    else
      put(NUL_BYTE, 1'b0);
  endtask

  // One text transfer; valid stays high when the next byte follows at once.
  task automatic send_text_item(input text_item_t it);
    while ($urandom_range(99) < send_idle) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid <= 1'b1;
    text_item  <= it;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
  endtask

  task automatic send_queued(input int n);
    repeat (n) send_text_item(text_seq.pop_front());
  endtask

  // Holds the sender until every owed byte has come and the pipe is empty.
  task automatic drain_results();
    text_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [15:0] v);
    cfg_valid      <= 1'b1;
    cfg_max_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int plan[12];
    int sent;
    int half;
    logic [15:0] size_value;

    text_valid     <= 1'b0;
    text_item      <= '0;
    cfg_valid      <= 1'b0;
    cfg_max_length <= '0;
    rst            <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle = 25;
    recv_idle = 53;

    // Directed text at the reset buffer size: byte extremes, every blank,
    // a collapsed run, a tag, a stray close, a pilcrow, held lead bytes
    // before a letter, before a tag and at the end of text.
    put("A", 1'b0);
    put(8'hFF, 1'b0);
    put(8'h01, 1'b0);
    put(SPACE_BYTE, 1'b0);
    put(TAB_BYTE, 1'b0);
    put(NEWLINE_BYTE, 1'b0);
    put(RETURN_BYTE, 1'b0);
    put("b", 1'b0);
    put(TAG_OPEN, 1'b0);
    put("x", 1'b0);
    put(TAG_CLOSE, 1'b0);
    put(TAG_CLOSE, 1'b0);
    put(LEAD_BYTE, 1'b0);
    put(PILCROW_TAIL, 1'b0);
    put(SPACE_BYTE, 1'b0);
    put(LEAD_BYTE, 1'b0);
    put("z", 1'b0);
    put(LEAD_BYTE, 1'b0);
    put(TAG_OPEN, 1'b0);
    put("q", 1'b0);
    put(TAG_CLOSE, 1'b0);
    put(SPACE_BYTE, 1'b0);
    put(LEAD_BYTE, 1'b0);
    put(8'h55, 1'b1);
    put(NUL_BYTE, 1'b0);
    send_queued(text_seq.size());

    // Random texts under a sequence of buffer sizes; zero picks a small
    // random size. Each phase may set a size of 1 to 4 once in mid-text.
    plan = '{1, 65535, 7, 0, 2, 16, 512, 0, 65535, 3, 30, 0};
    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 25 : (p == 1) ? 53 : 0;
      recv_idle = (p == 0) ? 53 : (p == 1) ? 25 : 0;
      for (int k = 0; k < 4; k++) begin
        drain_results();
        size_value = (plan[p*4+k] == 0) ? 16'($urandom_range(1, 40)) : 16'(plan[p*4+k]);
        write_max_length(size_value);
        sent = 0;
        while (sent < 22) begin
          build_text();
          sent += text_seq.size();
          if (k == 3 && sent == text_seq.size() && text_seq.size() > 4) begin
            half = text_seq.size() / 2;
            send_queued(half);
            drain_results();
            write_max_length(16'($urandom_range(1, 4)));
          end
          send_queued(text_seq.size());
        end
      end
    end

    drain_results();
    if (mismatches == 0 && results_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mssc_pkg.sv
rtl/markup_strip_space_collapse_unit.sv
tb/clean_text_checker.sv
tb/tb.sv
